@@ sv/akns_pkg.sv @@
package akns_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;
    localparam int OUT_W     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd4;

    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    typedef struct packed {
        logic [15:0] raw_min;
        logic [15:0] raw_max;
        logic        invert;
        logic [16:0] alpha;
        logic [15:0] deadband;
    } t_cfg;

endpackage

@@ sv/akns_cfg.sv @@
module akns_cfg
    import akns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_min  <= '0;
            r_cfg.raw_max  <= FULL_SCALE;
            r_cfg.invert   <= 1'b0;
            r_cfg.alpha    <= ALPHA_ONE;
            r_cfg.deadband <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RAW_MIN:  r_cfg.raw_min  <= i_cfg_data[15:0];
                CFG_RAW_MAX:  r_cfg.raw_max  <= i_cfg_data[15:0];
                CFG_INVERT:   r_cfg.invert   <= i_cfg_data[0];
                CFG_ALPHA:    r_cfg.alpha    <= i_cfg_data[16:0];
                CFG_DEADBAND: r_cfg.deadband <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/akns_div.sv @@
module akns_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    // quotient known to fit 16 bits: numerator < den * 2^16
    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [16:0] r_rem;
    logic [15:0] r_lo;
    logic [16:0] r_den;
    logic [15:0] r_quot;

    logic [17:0] w_shift;
    logic [17:0] w_trial;
    logic        w_fit;

    assign w_shift = {r_rem, r_lo[15]};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_fit   = !w_trial[17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[31:16]};
            r_lo  <= i_num[15:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_trial[16:0] : w_shift[16:0];
            r_lo   <= {r_lo[14:0], 1'b0};
            r_quot <= {r_quot[14:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ sv/adc_knob_normalize_smooth_unit.sv @@
// Knob normaliser: each transaction on s_axis carries one raw ADC sample, which is clamped
// to the calibrated travel, scaled to a 16-bit fraction by a 16-step restoring divider,
// optionally inverted and then smoothed with one 17x18 multiply and a deadband test (a
// command sample or the first after reset sets the level directly). The block is busy from
// acceptance, through the divider's one-bit-per-cycle loop, until its result is loaded into
// the m_axis output register, and takes no new sample before then. Config writes are
// accepted outside reset and should only be issued while the block is idle.
module adc_knob_normalize_smooth_unit
    import akns_pkg::*;
#(
    parameter int ADC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] sample
    input  logic                 s_axis_tuser,   // [0] command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] below_range, [1] above_range, [17:2] level, [34:18] bipolar_level,
    // [35] changed, [39:36] zero
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    localparam logic [31:0] MASK32 = 32'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [15:0] MASK   = MASK32[15:0];

    t_cfg w_cfg;

    logic [2:0]         r_state;
    logic               r_started;
    logic [15:0]        r_level;
    logic               r_cmd;
    logic [15:0]        r_raw;
    logic               r_below;
    logic               r_above;
    logic [15:0]        r_target;
    logic signed [34:0] r_prod;
    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;

    logic [15:0] w_lo;
    logic [16:0] w_hi;
    logic [15:0] w_clamp;
    logic [15:0] w_ofs;
    logic [31:0] w_num;
    logic [16:0] w_den;
    logic        w_div_start;
    logic        w_div_done;
    logic [15:0] w_quot;

    logic [16:0]        w_alpha;
    logic signed [16:0] w_diff;
    logic signed [17:0] w_alpha_s;
    logic signed [17:0] w_step;
    logic [17:0]        w_mag;
    logic signed [17:0] w_sum;
    logic [15:0]        w_upd_level;
    logic               w_upd_changed;
    logic               w_reinit;
    logic [15:0]        w_new_level;
    logic               w_new_changed;
    logic               w_out_free;
    logic [16:0]        w_bipolar;

    akns_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // clamp and scale operands
    assign w_lo    = w_cfg.raw_min;
    assign w_hi    = (w_cfg.raw_max > w_lo) ? {1'b0, w_cfg.raw_max} : {1'b0, w_lo} + 17'd1;
    assign w_clamp = (r_raw < w_lo) ? w_lo :
                     (({1'b0, r_raw} > w_hi) ? w_hi[15:0] : r_raw);
    assign w_ofs   = w_clamp - w_lo;
    assign w_num   = {w_ofs, 16'd0} - {16'd0, w_ofs};
    assign w_den   = w_hi - {1'b0, w_lo};

    assign w_div_start = (r_state == S_PREP);

    akns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // smoothing
    assign w_alpha   = (w_cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : w_cfg.alpha;
    assign w_diff    = $signed({1'b0, r_target}) - $signed({1'b0, r_level});
    assign w_alpha_s = $signed({1'b0, w_alpha});
    assign w_step    = r_prod[33:16];
    assign w_mag     = w_step[17] ? 18'(-w_step) : 18'(w_step);
    assign w_upd_changed = w_mag >= {2'b00, w_cfg.deadband};
    assign w_sum     = $signed({2'b00, r_level}) + w_step;
    assign w_upd_level = w_sum[17] ? 16'd0 : (w_sum[16] ? FULL_SCALE : w_sum[15:0]);

    assign w_reinit      = r_cmd || !r_started;
    assign w_new_level   = w_reinit ? r_target :
                           (w_upd_changed ? w_upd_level : r_level);
    assign w_new_changed = !w_reinit && w_upd_changed;
    assign w_bipolar     = {w_new_level, 1'b0} - {1'b0, FULL_SCALE};

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_level   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == S_UPD && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_out_free) begin
                        r_started <= 1'b1;
                        r_level   <= w_new_level;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_cmd <= s_axis_tuser;
            r_raw <= s_axis_tdata & MASK;
        end
        if (r_state == S_PREP) begin
            r_below <= r_raw < w_cfg.raw_min;
            r_above <= r_raw > w_cfg.raw_max;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_target <= w_cfg.invert ? FULL_SCALE - w_quot : w_quot;
        end
        if (r_state == S_MUL) begin
            r_prod <= 35'(w_diff) * 35'(w_alpha_s);
        end
        if (r_state == S_UPD && w_out_free) begin
            r_m_data <= {4'd0, w_new_changed, w_bipolar, w_new_level, r_above, r_below};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign o_cfg_ready   = i_rst_n;

endmodule

@@ sv/akns_chk.sv @@
module akns_chk
    import akns_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_W-1:0]     m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    a_bipolar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[34:18] == ({m_axis_tdata[17:2], 1'b0} - 17'd65535))
        else $error("bipolar level does not match level");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind adc_knob_normalize_smooth_unit akns_chk u_akns_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
